// ----- sv/wtmf_pkg.sv -----
// Shared types and constants for the window trimmed median filter.
package wtmf_pkg;

  localparam int WINDOW_SIZE = 8;
  localparam int SAMPLE_W    = 16;
  localparam int AGE_W       = $clog2(WINDOW_SIZE);
  localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);
  localparam int RANK_LO     = WINDOW_SIZE / 2 - 2;
  localparam int SUM_W       = SAMPLE_W + 2;
  localparam int DIV_SHIFT   = 19;

  localparam logic [SUM_W-1:0] DIV_MUL = SUM_W'((1 << DIV_SHIFT) / 3 + 1);
  localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(WINDOW_SIZE - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_SIZE);

  typedef struct packed {
    logic                valid;
    logic [AGE_W-1:0]    age;
    logic [SAMPLE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic del_seen;
    logic keep;
  } link_t;

  typedef struct packed {
    logic                valid;
    logic                full;
    logic [SAMPLE_W-1:0] sample;
  } tag_t;

endpackage

// ----- sv/wtmf_cell.sv -----
// One cell of the sorted window: holds one entry with its age.
module wtmf_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic [wtmf_pkg::SAMPLE_W-1:0]    sample,
  input  wtmf_pkg::entry_t                 above,
  input  wtmf_pkg::entry_t                 below,
  input  wtmf_pkg::link_t                  link_in,
  output wtmf_pkg::link_t                  link_out,
  output wtmf_pkg::entry_t                 entry
);

  wtmf_pkg::entry_t entry_r;
  wtmf_pkg::entry_t entry_nxt;
  wtmf_pkg::entry_t after_del;
  wtmf_pkg::entry_t prev_after_del;
  logic             del_here;
  logic             del_seen;
  logic             keep;

  always_comb begin
    del_here       = entry_r.valid && (entry_r.age == wtmf_pkg::AGE_OLDEST);
    del_seen       = link_in.del_seen | del_here;
    after_del      = del_seen ? below : entry_r;
    prev_after_del = link_in.del_seen ? entry_r : above;
    keep           = after_del.valid && (after_del.value >= sample);
  end

  always_comb begin
    if (keep) begin
      entry_nxt     = after_del;
      entry_nxt.age = after_del.age + 1'b1;
    end else if (link_in.keep) begin
      entry_nxt.valid = 1'b1;
      entry_nxt.age   = '0;
      entry_nxt.value = sample;
    end else begin
      entry_nxt     = prev_after_del;
      entry_nxt.age = prev_after_del.age + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else if (en) begin
      entry_r <= entry_nxt;
    end
  end

  assign link_out.del_seen = del_seen;
  assign link_out.keep     = keep;
  assign entry             = entry_r;

endmodule

// ----- sv/wtmf_avg.sv -----
// Sum and divide-by-three stages that form the result item.
module wtmf_avg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  wtmf_pkg::tag_t                tag,
  input  logic [wtmf_pkg::SAMPLE_W-1:0] rank0,
  input  logic [wtmf_pkg::SAMPLE_W-1:0] rank1,
  input  logic [wtmf_pkg::SAMPLE_W-1:0] rank2,
  output logic                          out_valid,
  output logic [wtmf_pkg::SAMPLE_W-1:0] out_filtered,
  output logic                          out_window_full
);

  logic [wtmf_pkg::SUM_W-1:0]   sum;
  logic [wtmf_pkg::SUM_W-1:0]   val2_nxt;
  logic [wtmf_pkg::SUM_W-1:0]   val2_r;
  logic                         v2_r;
  logic                         full2_r;
  logic [2*wtmf_pkg::SUM_W-1:0] prod;
  logic [wtmf_pkg::SAMPLE_W-1:0] filt_nxt;
  logic                         v3_r;
  logic                         full3_r;
  logic [wtmf_pkg::SAMPLE_W-1:0] filt3_r;

  always_comb begin
    sum = {2'b00, rank0} + {2'b00, rank1} + {2'b00, rank2};
    val2_nxt = tag.full ? sum : {2'b00, tag.sample};
  end

  assign prod     = val2_r * wtmf_pkg::DIV_MUL;
  assign filt_nxt = full2_r ? prod[wtmf_pkg::DIV_SHIFT +: wtmf_pkg::SAMPLE_W]
                            : val2_r[wtmf_pkg::SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v2_r <= tag.valid;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      full2_r <= tag.full;
      val2_r  <= val2_nxt;
      full3_r <= full2_r;
      filt3_r <= filt_nxt;
    end
  end

  assign out_valid       = v3_r;
  assign out_filtered    = filt3_r;
  assign out_window_full = full3_r;

endmodule

// ----- sv/window_trimmed_median_filter.sv -----
// Top level of the window trimmed median filter: sorted cell chain and averaging stages.
//
//   channel | direction | ports
//   in      | input     | in_valid, in_stall, in_sample
//   out     | output    | out_valid, out_stall, out_filtered, out_window_full
//
// One item is accepted per cycle while the output is not stalled; its result is
// registered in the cell chain update, then the sum register, then the divide register.
// The cell chain sets this rate: it inserts one sample and, once the window is full,
// retires the oldest entry in the same cycle.
// Reset clears the cell valid bits, the fill count and the stage valids.
// A stalled output holds the whole pipeline and raises in_stall.
module window_trimmed_median_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wtmf_pkg::SAMPLE_W-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wtmf_pkg::SAMPLE_W-1:0] out_filtered,
  output logic                          out_window_full
);

  localparam int W = wtmf_pkg::WINDOW_SIZE;

  logic                       en;
  logic                       accept;
  logic                       full;
  logic [wtmf_pkg::CNT_W-1:0] cnt_r;
  wtmf_pkg::tag_t             tag_r;
  wtmf_pkg::entry_t           ent  [W];
  wtmf_pkg::link_t            lnk  [W];
  wtmf_pkg::entry_t           empty_entry;
  wtmf_pkg::link_t            head_link;

  assign en          = !(out_valid && out_stall);
  assign in_stall    = !en;
  assign accept      = in_valid && en;
  assign full        = (cnt_r == wtmf_pkg::CNT_FULL);
  assign empty_entry = '0;
  assign head_link   = '{del_seen: 1'b0, keep: 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      tag_r.valid <= 1'b0;
    end else if (en) begin
      tag_r.valid <= accept;
      if (accept) begin
        tag_r.full   <= full;
        tag_r.sample <= in_sample;
      end
      if (accept && !full) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_cell
    wtmf_pkg::entry_t above;
    wtmf_pkg::entry_t below;
    wtmf_pkg::link_t  link_in;

    if (i == 0) begin : g_head
      assign above   = empty_entry;
      assign link_in = head_link;
    end else begin : g_mid
      assign above   = ent[i-1];
      assign link_in = lnk[i-1];
    end

    if (i == W - 1) begin : g_tail
      assign below = empty_entry;
    end else begin : g_body
      assign below = ent[i+1];
    end

    wtmf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (accept),
      .sample   (in_sample),
      .above    (above),
      .below    (below),
      .link_in  (link_in),
      .link_out (lnk[i]),
      .entry    (ent[i])
    );
  end

  wtmf_avg u_avg (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .tag             (tag_r),
    .rank0           (ent[wtmf_pkg::RANK_LO].value),
    .rank1           (ent[wtmf_pkg::RANK_LO + 1].value),
    .rank2           (ent[wtmf_pkg::RANK_LO + 2].value),
    .out_valid       (out_valid),
    .out_filtered    (out_filtered),
    .out_window_full (out_window_full)
  );

endmodule

// ----- sv/wtmf_checker.sv -----
// Port-level checks for the window trimmed median filter, bound to the top level.
module wtmf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [wtmf_pkg::SAMPLE_W-1:0] in_sample,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [wtmf_pkg::SAMPLE_W-1:0] out_filtered,
  input logic                          out_window_full
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_sample))
    else $error("input item changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_filtered) && $stable(out_window_full))
    else $error("result item changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result item");

  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_full |=> !out_valid || out_window_full)
    else $error("window_full fell after the window filled");

endmodule

bind window_trimmed_median_filter wtmf_checker u_wtmf_checker (.*);

// ----- dv/tb_window_trimmed_median_filter.sv -----
// Testbench for the window trimmed median filter: directed and random streams.
module tb_window_trimmed_median_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W     = wtmf_pkg::SAMPLE_W;
  localparam int WINDOW_SIZE  = wtmf_pkg::WINDOW_SIZE;
  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 13;
  localparam int STEADY_FIRST = 300;
  localparam int STEADY_LAST  = 460;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered;
    logic                window_full;
  } median_t;

  typedef enum int {MIX_FULL, MIX_TIES, MIX_HIGH, MIX_CLUSTER} sample_mix_e;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SAMPLE_W-1:0] out_filtered;
  logic                out_window_full;

  logic [SAMPLE_W-1:0] ring [WINDOW_SIZE];
  int                  ring_pos   = 0;
  int                  ring_fill  = 0;
  median_t             median_q[$];
  int                  mismatches = 0;
  int                  cycles     = 0;
  bit                  steady     = 1'b0;

  always #5 clk = ~clk;

  window_trimmed_median_filter u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_filtered    (out_filtered),
    .out_window_full (out_window_full)
  );

  function automatic median_t predict_filtered(logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] view [WINDOW_SIZE];
    logic [SAMPLE_W-1:0] key;
    int                  i;
    int                  j;
    int                  sum;
    median_t             m;
    ring[ring_pos] = s;
    ring_pos = (ring_pos + 1) % WINDOW_SIZE;
    if (ring_fill < WINDOW_SIZE) begin
      ring_fill++;
      m.filtered    = s;
      m.window_full = 1'b0;
      return m;
    end
    view = ring;
    for (i = 1; i < WINDOW_SIZE; i++) begin
      key = view[i];
      j   = i;
      while (j > 0 && view[j-1] < key) begin
        view[j] = view[j-1];
        j--;
      end
      view[j] = key;
    end
    sum = 0;
    for (i = WINDOW_SIZE / 2 - 2; i <= WINDOW_SIZE / 2; i++) sum += int'(view[i]);
    m.filtered    = SAMPLE_W'(sum / 3);
    m.window_full = 1'b1;
    return m;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid  <= 1'b0;
      in_sample <= SAMPLE_W'($urandom);
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    median_q.push_back(predict_filtered(s));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (median_q.size() != 0);
  endtask

  task automatic test_fill_passthrough();
    logic [SAMPLE_W-1:0] fill [WINDOW_SIZE] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001,
                                                16'h7FFF, 16'hAAAA, 16'h5555, 16'hFFFE};
    foreach (fill[i]) send_sample(fill[i]);
  endtask

  task automatic test_saturated_window();
    repeat (WINDOW_SIZE) send_sample(16'hFFFF);
  endtask

  task automatic test_empty_window();
    repeat (WINDOW_SIZE) send_sample(16'h0000);
  endtask

  task automatic test_random_stream();
    sample_mix_e         mix;
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] s;
    mix  = MIX_FULL;
    base = '0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= STEADY_FIRST && n < STEADY_LAST);
      if (n % 16 == 0) begin
        mix  = sample_mix_e'($urandom_range(3));
        base = SAMPLE_W'($urandom);
      end
      unique case (mix)
        MIX_FULL:    s = SAMPLE_W'($urandom);
        MIX_TIES:    s = SAMPLE_W'($urandom_range(3));
        MIX_HIGH:    s = 16'hFFFF - SAMPLE_W'($urandom_range(3));
        MIX_CLUSTER: s = base + SAMPLE_W'($urandom_range(7));
      endcase
      send_sample(s);
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin : check_results
    median_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (median_q.size() == 0) begin
        note_mismatch($sformatf("unexpected item: filtered=%h window_full=%b",
                                out_filtered, out_window_full));
      end else begin
        want = median_q.pop_front();
        if (out_filtered !== want.filtered || out_window_full !== want.window_full) begin
          note_mismatch($sformatf("filtered exp=%h got=%h, window_full exp=%b got=%b",
                                  want.filtered, out_filtered, want.window_full,
                                  out_window_full));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("window_trimmed_median_filter verification failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_passthrough();
    drain_results();
    test_saturated_window();
    test_empty_window();
    drain_results();
    test_random_stream();
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && median_q.size() == 0) begin
      $display("window_trimmed_median_filter verification clean");
    end else begin
      $display("window_trimmed_median_filter verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/wtmf_pkg.sv
sv/wtmf_cell.sv
sv/wtmf_avg.sv
sv/window_trimmed_median_filter.sv
sv/wtmf_checker.sv
dv/tb_window_trimmed_median_filter.sv
